// ===== sv/lsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared types, codes and reset values of the LIN slave frame engine.
// ----------------------------------------------------------------------------
package lsfe_pkg;

   localparam int MAX_BYTES_DEF = 8;

   localparam logic [7:0]  SYNC_VALUE_RST    = 8'h55;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

   // register indexes of the configuration port
   localparam logic CSR_SYNC_VALUE    = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   typedef enum logic [2:0] {
      REQ_BREAK    = 3'd0,
      REQ_RX_BYTE  = 3'd1,
      REQ_START_RX = 3'd2,
      REQ_TX_BYTE  = 3'd3,
      REQ_TICK     = 3'd4
   } req_code_type;

   typedef enum logic [3:0] {
      ST_ID          = 4'd0,
      ST_DATA        = 4'd1,
      ST_FRAME_OK    = 4'd2,
      ST_BAD_CHKSUM  = 4'd3,
      ST_TIMEOUT     = 4'd4,
      ST_BAD_LENGTH  = 4'd5,
      ST_NO_ID       = 4'd6,
      ST_TX_BYTE     = 4'd7,
      ST_TX_CHECKSUM = 4'd8
   } status_code_type;

   typedef struct packed {
      logic [3:0] status;
      logic [7:0] value;
      logic [2:0] position;
      logic       last;
   } rsp_word_type;

   // words produced by one request, pushed into the result queue together
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type w0;
      rsp_word_type w1;
   } push_type;

endpackage

// ===== sv/lsfe_frame_fsm.sv =====
// ----------------------------------------------------------------------------
// lsfe_frame_fsm
// Frame tracking state, checksum and idle counter; turns one accepted
// request combinationally into zero, one or two result words.
// ----------------------------------------------------------------------------
module lsfe_frame_fsm
   import lsfe_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        take,
   input  logic [2:0]  req_type,
   input  logic [7:0]  byte_value,
   input  logic [7:0]  expected_length,
   input  logic        final_byte,
   output push_type    push
);

   typedef enum logic [2:0] {
      FS_WAIT_BREAK = 3'd0,
      FS_SYNC       = 3'd1,
      FS_ID         = 3'd2,
      FS_WAIT_CMD   = 3'd3,
      FS_RX_DATA    = 3'd4,
      FS_RX_CRC     = 3'd5,
      FS_SENDING    = 3'd6
   } frame_state_type;

   localparam logic [3:0] MAX_CNT = 4'(MAX_BYTES);

   frame_state_type state_ff, state_in, st_eff;
   logic [3:0]  len_ff, len_in;
   logic [3:0]  cnt_ff, cnt_in, cnt_eff, cnt_inc;
   logic [7:0]  sum_ff, sum_in, sum_eff, sum_new;
   logic [15:0] idle_ff, idle_in;
   logic [16:0] idle_next;
   logic [7:0]  sync_ff;
   logic [15:0] tmo_ff;
   push_type    push_c;

   function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, s} + {1'b0, b};
      // end-around carry: taking 0xFF off equals folding the carry back in
      return t[7:0] + {7'd0, t[8]};
   endfunction

   function automatic rsp_word_type mk(input status_code_type st, input logic [7:0] v,
                                       input logic [2:0] p);
      rsp_word_type w;
      w.status   = st;
      w.value    = v;
      w.position = p;
      w.last     = 1'b0;
      return w;
   endfunction

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      idle_in   = idle_ff;
      push_c    = '0;
      st_eff    = state_ff;
      cnt_eff   = cnt_ff;
      sum_eff   = sum_ff;
      // a transmit straight after the ID opens a fresh sending frame
      if (state_ff == FS_WAIT_CMD) begin
         st_eff  = FS_SENDING;
         cnt_eff = 4'd0;
         sum_eff = 8'd0;
      end
      cnt_inc   = cnt_ff + 4'd1;
      sum_new   = sum_add(sum_ff, byte_value);
      idle_next = {1'b0, idle_ff} + 17'd1;
      if (take) begin
         case (req_code_type'(req_type))
            REQ_BREAK: begin
               if (state_ff == FS_RX_DATA || state_ff == FS_RX_CRC) begin
                  push_c.count = 2'd1;
                  push_c.w0    = mk(ST_TIMEOUT, 8'd0, 3'd0);
               end
               state_in = FS_SYNC;
               idle_in  = 16'd0;
            end
            REQ_RX_BYTE: begin
               case (state_ff)
                  FS_SYNC: begin
                     state_in = (byte_value == sync_ff) ? FS_ID : FS_WAIT_BREAK;
                  end
                  FS_ID: begin
                     push_c.count = 2'd1;
                     push_c.w0    = mk(ST_ID, byte_value, 3'd0);
                     state_in     = FS_WAIT_CMD;
                  end
                  FS_RX_DATA: begin
                     push_c.count = 2'd1;
                     push_c.w0    = mk(ST_DATA, byte_value, cnt_ff[2:0]);
                     sum_in       = sum_new;
                     cnt_in       = cnt_inc;
                     idle_in      = 16'd0;
                     if (cnt_inc >= len_ff) begin
                        state_in = FS_RX_CRC;
                     end
                  end
                  FS_RX_CRC: begin
                     push_c.count = 2'd1;
                     push_c.w0    = mk((~sum_ff == byte_value) ? ST_FRAME_OK : ST_BAD_CHKSUM,
                                       byte_value, 3'd0);
                     state_in     = FS_WAIT_BREAK;
                  end
                  default: begin
                     // own echo or stray byte: drop
                  end
               endcase
            end
            REQ_START_RX: begin
               push_c.count = 2'd1;
               if (state_ff != FS_WAIT_CMD) begin
                  push_c.w0 = mk(ST_NO_ID, 8'd0, 3'd0);
               end else if (expected_length < 8'd1 ||
                            expected_length > 8'(MAX_BYTES)) begin
                  push_c.w0 = mk(ST_BAD_LENGTH, 8'd0, 3'd0);
                  state_in  = FS_WAIT_BREAK;
               end else begin
                  push_c.count = 2'd0;
                  state_in     = FS_RX_DATA;
                  len_in       = expected_length[3:0];
                  cnt_in       = 4'd0;
                  sum_in       = 8'd0;
                  idle_in      = 16'd0;
               end
            end
            REQ_TX_BYTE: begin
               push_c.count = 2'd1;
               if (st_eff != FS_SENDING) begin
                  push_c.w0 = mk(ST_NO_ID, 8'd0, 3'd0);
               end else if (cnt_eff >= MAX_CNT) begin
                  push_c.w0 = mk(ST_BAD_LENGTH, 8'd0, 3'd0);
                  state_in  = FS_WAIT_BREAK;
               end else begin
                  push_c.w0 = mk(ST_TX_BYTE, byte_value, cnt_eff[2:0]);
                  state_in  = FS_SENDING;
                  sum_in    = sum_add(sum_eff, byte_value);
                  cnt_in    = cnt_eff + 4'd1;
                  if (final_byte) begin
                     push_c.count = 2'd2;
                     push_c.w1    = mk(ST_TX_CHECKSUM, ~sum_add(sum_eff, byte_value), 3'd0);
                     state_in     = FS_WAIT_BREAK;
                  end
               end
            end
            REQ_TICK: begin
               if (state_ff == FS_RX_DATA || state_ff == FS_RX_CRC) begin
                  if (idle_next > {1'b0, tmo_ff}) begin
                     push_c.count = 2'd1;
                     push_c.w0    = mk(ST_TIMEOUT, 8'd0, 3'd0);
                     state_in     = FS_WAIT_BREAK;
                     idle_in      = 16'd0;
                  end else begin
                     idle_in = idle_next[15:0];
                  end
               end
            end
            default: begin
               // unused request codes: drop
            end
         endcase
      end
      // mark the final word of this request
      if (push_c.count == 2'd1) begin
         push_c.w0.last = 1'b1;
      end
      if (push_c.count == 2'd2) begin
         push_c.w1.last = 1'b1;
      end
   end

   assign push = push_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_WAIT_BREAK;
         len_ff   <= 4'd0;
         cnt_ff   <= 4'd0;
         sum_ff   <= 8'd0;
         idle_ff  <= 16'd0;
         sync_ff  <= SYNC_VALUE_RST;
         tmo_ff   <= TIMEOUT_TICKS_RST;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         idle_ff  <= idle_in;
         if (csr_we && csr_index == CSR_SYNC_VALUE) begin
            sync_ff <= csr_wdata[7:0];
         end
         if (csr_we && csr_index == CSR_TIMEOUT_TICKS) begin
            tmo_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== sv/lsfe_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// lsfe_rsp_fifo
// Four-entry result queue; takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
module lsfe_rsp_fifo
   import lsfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   output logic         has_room,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   rsp_word_type mem_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign out_valid = (cnt_ff != 3'd0);
   assign out_word  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   // room for the worst case of two words, whether or not a word leaves
   assign has_room  = (cnt_ff <= 3'd2);

   always_comb begin
      wr_in  = wr_ff + push.count;
      rd_in  = rd_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.w0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + 2'd1] <= push.w1;
      end
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/lin_slave_frame_engine.sv =====
// ----------------------------------------------------------------------------
// lin_slave_frame_engine
// LIN slave frame engine with classic checksum: tracks break, sync, ID and
// data phases, forwards bytes and checks or appends the checksum.
// ----------------------------------------------------------------------------
//   channel   direction  ports                           handshake
//   req       in         req_type req_byte_value         req_valid/req_ready
//                        req_expected_length req_final_byte
//   rsp       out        rsp_status rsp_value            rsp_valid/rsp_ready
//                        rsp_position rsp_last
//   csr       in         csr_index csr_wdata             csr_we
//
// A request is handled in the cycle it is accepted; its 0 to 2 result words
// are registered into a four-entry queue and offered behind any waiting ones.
// One request per cycle is taken while the queue has room for two words.
// The result port gives one word per cycle while rsp_ready is high, so a
// transmit with its final mark yields two words. Reset is synchronous and
// clears the frame state, the queue and the registers to their defaults.
// ----------------------------------------------------------------------------
module lin_slave_frame_engine
   import lsfe_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_byte_value,
   input  logic [7:0]  req_expected_length,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_value,
   output logic [2:0]  rsp_position,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   push_type     push;
   rsp_word_type word;
   logic         take;

   assign take = req_valid && req_ready;

   lsfe_frame_fsm #(
      .MAX_BYTES(MAX_BYTES)
   ) u_fsm (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .take           (take),
      .req_type       (req_type),
      .byte_value     (req_byte_value),
      .expected_length(req_expected_length),
      .final_byte     (req_final_byte),
      .push           (push)
   );

   lsfe_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .has_room (req_ready),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_word (word)
   );

   assign rsp_status   = word.status;
   assign rsp_value    = word.value;
   assign rsp_position = word.position;
   assign rsp_last     = word.last;

endmodule

// ===== sv/lsfe_checker.sv =====
// ----------------------------------------------------------------------------
// lsfe_checker
// Port-level checks of the LIN slave frame engine, bound to the top level.
// ----------------------------------------------------------------------------
module lsfe_checker
   import lsfe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_status,
   input logic [7:0]  rsp_value,
   input logic [2:0]  rsp_position,
   input logic        rsp_last
);

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result word offered after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value)
                                  && $stable(rsp_position) && $stable(rsp_last))
      else $error("stalled result word changed");

   // the appended checksum always closes its request
   a_chk_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_TX_CHECKSUM |-> rsp_last)
      else $error("tx checksum not marked last");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_TIMEOUT || rsp_status == ST_BAD_LENGTH ||
                    rsp_status == ST_NO_ID)
      |-> rsp_value == 8'd0 && rsp_position == 3'd0 && rsp_last)
      else $error("error word carries payload");

endmodule

bind lin_slave_frame_engine lsfe_checker u_lsfe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_status  (rsp_status),
   .rsp_value   (rsp_value),
   .rsp_position(rsp_position),
   .rsp_last    (rsp_last)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the LIN slave frame engine against a cycle-free frame predictor.
// A short table walks the frame states and the no-ID, bad-length and break
// timeout paths, then random frames (mostly well-formed, some broken, some
// noise) run under six settings, both channels idling and stalling in five.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import lsfe_pkg::*;

   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;
   localparam int PHASE_WORDS = 285;

   typedef enum logic [2:0] {
      FS_WAIT_BREAK, FS_SYNC, FS_ID, FS_WAIT_CMD, FS_RX_DATA, FS_RX_CHK, FS_SENDING
   } frame_phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] bval;
      logic [7:0] blen;
      logic       fin;
      logic       typed;
      logic [3:0] t_status;
      logic [7:0] t_value;
   } dir_row_type;

   localparam int DIR_ROWS = 40;
   // kind, byte, length, final, typed, status, value
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{REQ_RX_BYTE,  8'h12, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TICK,     8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_START_RX, 8'h00, 8'h03, 1'b0, 1'b1, ST_NO_ID,      8'h00},
      '{REQ_TX_BYTE,  8'h5A, 8'h00, 1'b1, 1'b1, ST_NO_ID,      8'h00},
      '{REQ_SPARE_7,  8'hFF, 8'hFF, 1'b1, 1'b0, ST_ID,         8'h00},
      '{REQ_BREAK,    8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'hAA, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_BREAK,    8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h55, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b1, ST_ID,         8'hFF},
      '{REQ_RX_BYTE,  8'h33, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_BREAK,    8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h55, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h00, 8'h00, 1'b0, 1'b1, ST_ID,         8'h00},
      '{REQ_START_RX, 8'h00, 8'h00, 1'b0, 1'b1, ST_BAD_LENGTH, 8'h00},
      '{REQ_BREAK,    8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h55, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h3C, 8'h00, 1'b0, 1'b1, ST_ID,         8'h3C},
      '{REQ_START_RX, 8'h00, 8'h09, 1'b0, 1'b1, ST_BAD_LENGTH, 8'h00},
      '{REQ_BREAK,    8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h55, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h80, 8'h00, 1'b0, 1'b1, ST_ID,         8'h80},
      '{REQ_START_RX, 8'hFF, 8'h02, 1'b1, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TICK,     8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_BREAK,    8'h00, 8'h00, 1'b0, 1'b1, ST_TIMEOUT,    8'h00},
      '{REQ_RX_BYTE,  8'h55, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_RX_BYTE,  8'h7F, 8'h00, 1'b0, 1'b1, ST_ID,         8'h7F},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'hFF, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'h00, 8'h00, 1'b0, 1'b0, ST_ID,         8'h00},
      '{REQ_TX_BYTE,  8'h11, 8'h00, 1'b0, 1'b1, ST_BAD_LENGTH, 8'h00},
      '{REQ_TX_BYTE,  8'h01, 8'h00, 1'b1, 1'b1, ST_NO_ID,      8'h00}
   };

   logic        clock;
   logic        reset               = 1'b1;
   logic        req_valid           = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type            = REQ_TICK;
   logic [7:0]  req_byte_value      = 8'h00;
   logic [7:0]  req_expected_length = 8'h00;
   logic        req_final_byte      = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready           = 1'b0;
   logic [3:0]  rsp_status;
   logic [7:0]  rsp_value;
   logic [2:0]  rsp_position;
   logic        rsp_last;
   logic        csr_we              = 1'b0;
   logic        csr_index           = CSR_SYNC_VALUE;
   logic [15:0] csr_wdata           = 16'h0000;

   // frame predictor state and register copies
   frame_phase_type fs        = FS_WAIT_BREAK;
   logic [3:0]      want_len  = 4'd0;
   logic [3:0]      nbytes    = 4'd0;
   logic [7:0]      csum      = 8'h00;
   logic [15:0]     idle      = 16'd0;
   logic [7:0]      cfg_sync  = SYNC_VALUE_RST;
   logic [15:0]     cfg_ticks = TIMEOUT_TICKS_RST;

   rsp_word_type frame_words [2];
   int           frame_nwords;
   rsp_word_type rsp_due [$];
   int           mismatches = 0;
   int           items_sent = 0;
   bit           no_idle    = 1'b0;

   lin_slave_frame_engine DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_byte_value      (req_byte_value),
      .req_expected_length (req_expected_length),
      .req_final_byte      (req_final_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_value           (rsp_value),
      .rsp_position        (rsp_position),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [7:0] rb();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic rbit();
      return 1'($urandom_range(0, 1));
   endfunction

   // end-around carry byte add
   function automatic logic [7:0] lin_add(input logic [7:0] s, input logic [7:0] b);
      logic [8:0] t;
      t = {1'b0, s} + {1'b0, b};
      if (t > 9'h0FF) t = t - 9'h0FF;
      return t[7:0];
   endfunction

   function automatic void emit(input status_code_type st, input logic [7:0] v,
                                input logic [2:0] pos);
      if (frame_nwords > 0) frame_words[frame_nwords - 1].last = 1'b0;
      frame_words[frame_nwords] = '{status: st, value: v, position: pos, last: 1'b1};
      frame_nwords++;
   endfunction

   // advance the frame state for one accepted word, collect its results
   function automatic void follow_frame(input logic [2:0] kind, input logic [7:0] b,
                                        input logic [7:0] len, input logic fin);
      frame_nwords = 0;
      case (kind)
         REQ_BREAK: begin
            if (fs == FS_RX_DATA || fs == FS_RX_CHK) emit(ST_TIMEOUT, 8'h00, 3'd0);
            fs = FS_SYNC;
            idle = 16'd0;
         end
         REQ_RX_BYTE: begin
            case (fs)
               FS_SYNC: fs = (b == cfg_sync) ? FS_ID : FS_WAIT_BREAK;
               FS_ID: begin
                  emit(ST_ID, b, 3'd0);
                  fs = FS_WAIT_CMD;
               end
               FS_RX_DATA: begin
                  emit(ST_DATA, b, nbytes[2:0]);
                  csum = lin_add(csum, b);
                  nbytes = nbytes + 4'd1;
                  idle = 16'd0;
                  if (nbytes >= want_len) fs = FS_RX_CHK;
               end
               FS_RX_CHK: begin
                  emit(((csum ^ 8'hFF) == b) ? ST_FRAME_OK : ST_BAD_CHKSUM, b, 3'd0);
                  fs = FS_WAIT_BREAK;
               end
               default: ;
            endcase
         end
         REQ_START_RX: begin
            if (fs != FS_WAIT_CMD) begin
               emit(ST_NO_ID, 8'h00, 3'd0);
            end else if (len < 8'd1 || len > MAX_BYTES_DEF) begin
               emit(ST_BAD_LENGTH, 8'h00, 3'd0);
               fs = FS_WAIT_BREAK;
            end else begin
               fs = FS_RX_DATA;
               want_len = len[3:0];
               nbytes = 4'd0;
               csum = 8'h00;
               idle = 16'd0;
            end
         end
         REQ_TX_BYTE: begin
            if (fs == FS_WAIT_CMD) begin
               fs = FS_SENDING;
               nbytes = 4'd0;
               csum = 8'h00;
            end
            if (fs != FS_SENDING) begin
               emit(ST_NO_ID, 8'h00, 3'd0);
            end else if (nbytes >= MAX_BYTES_DEF) begin
               emit(ST_BAD_LENGTH, 8'h00, 3'd0);
               fs = FS_WAIT_BREAK;
            end else begin
               emit(ST_TX_BYTE, b, nbytes[2:0]);
               csum = lin_add(csum, b);
               nbytes = nbytes + 4'd1;
               if (fin) begin
                  emit(ST_TX_CHECKSUM, csum ^ 8'hFF, 3'd0);
                  fs = FS_WAIT_BREAK;
               end
            end
         end
         REQ_TICK: begin
            if (fs == FS_RX_DATA || fs == FS_RX_CHK) begin
               if ({1'b0, idle} + 17'd1 > {1'b0, cfg_ticks}) begin
                  emit(ST_TIMEOUT, 8'h00, 3'd0);
                  fs = FS_WAIT_BREAK;
                  idle = 16'd0;
               end else begin
                  idle = idle + 16'd1;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // hold valid and payload until the word is taken, then log what it causes
   task automatic put_req(input logic [2:0] kind, input logic [7:0] b, input logic [7:0] len,
                          input logic fin, input logic typed, input logic [3:0] t_status,
                          input logic [7:0] t_value);
      rsp_word_type w;
      while (!no_idle && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_byte_value      <= b;
      req_expected_length <= len;
      req_final_byte      <= fin;
      do @(posedge clock); while (!req_ready);
      follow_frame(kind, b, len, fin);
      if (typed) begin
         w = '{status: t_status, value: t_value, position: 3'd0, last: 1'b1};
         rsp_due.push_back(w);
      end else begin
         for (int k = 0; k < frame_nwords; k++) rsp_due.push_back(frame_words[k]);
      end
      items_sent++;
   endtask

   task automatic req(input logic [2:0] kind, input logic [7:0] b, input logic [7:0] len,
                      input logic fin);
      put_req(kind, b, len, fin, 1'b0, ST_ID, 8'h00);
   endtask

   task automatic noise_req();
      logic [2:0] kind;
      kind = ($urandom_range(0, 99) < 3) ? 3'($urandom_range(REQ_SPARE_5, REQ_SPARE_7))
                                         : 3'($urandom_range(REQ_BREAK, REQ_TICK));
      req(kind, rb(), rb(), rbit());
   endtask

   // a few ticks, now and then enough to time out if the timeout is under 12
   task automatic idle_ticks();
      int nt;
      if ($urandom_range(0, 99) < 20) nt = (cfg_ticks < 16'd12) ? int'(cfg_ticks) + 1 : 3;
      else nt = $urandom_range(0, 2);
      repeat (nt) req(REQ_TICK, rb(), rb(), rbit());
   endtask

   task automatic run_frame();
      int         pick;
      int         n;
      bit         over;
      logic [7:0] len;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         repeat ($urandom_range(1, 4)) noise_req();
         return;
      end
      req(REQ_BREAK, rb(), rb(), rbit());
      if (pick < 14) begin
         req(REQ_RX_BYTE, cfg_sync ^ (rb() | 8'h01), rb(), rbit());
         return;
      end
      req(REQ_RX_BYTE, cfg_sync, rb(), rbit());
      req(REQ_RX_BYTE, rb(), rb(), rbit());
      // echo of the slave's own line activity
      if ($urandom_range(0, 9) == 0) req(REQ_RX_BYTE, rb(), rb(), rbit());
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 11) == 0) len = rbit() ? 8'd0 : 8'($urandom_range(9, 255));
         else len = 8'($urandom_range(1, 8));
         req(REQ_START_RX, rb(), len, rbit());
         while (fs == FS_RX_DATA) begin
            idle_ticks();
            if (fs != FS_RX_DATA) break;
            if ($urandom_range(0, 39) == 0) begin
               req(REQ_BREAK, rb(), rb(), rbit());
               return;
            end
            req(REQ_RX_BYTE, rb(), rb(), rbit());
         end
         if (fs == FS_RX_CHK) idle_ticks();
         if (fs == FS_RX_CHK)
            req(REQ_RX_BYTE, ($urandom_range(0, 2) != 0) ? (csum ^ 8'hFF) : rb(), rb(), rbit());
      end else if (pick < 90) begin
         over = ($urandom_range(0, 9) == 0);
         n = over ? MAX_BYTES_DEF + 1 : $urandom_range(1, MAX_BYTES_DEF);
         for (int i = 0; i < n; i++) begin
            // drop out mid-transmit; the next break abandons it
            if ($urandom_range(0, 49) == 0) return;
            req(REQ_TX_BYTE, rb(), rb(), !over && i == n - 1);
         end
      end else begin
         repeat ($urandom_range(1, 4)) noise_req();
      end
   endtask

   // registers change only with the engine drained
   task automatic set_reg(input logic idx, input logic [15:0] data);
      req_valid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_SYNC_VALUE) cfg_sync = data[7:0];
      else cfg_ticks = data;
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] got);
      if (got !== exp_v) begin
         $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 31);
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected word: expected none got status %0d value %0d",
                     $time, rsp_status, rsp_value);
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_status));
            check_field("value", want.value, rsp_value);
            check_field("position", 8'(want.position), 8'(rsp_position));
            check_field("last", 8'(want.last), 8'(rsp_last));
         end
      end
   end

   initial begin
      int          phase_end;
      logic [7:0]  sync_pick;
      logic [15:0] ticks_pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++)
         put_req(DIR_TABLE[r].kind, DIR_TABLE[r].bval, DIR_TABLE[r].blen, DIR_TABLE[r].fin,
                 DIR_TABLE[r].typed, DIR_TABLE[r].t_status, DIR_TABLE[r].t_value);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               sync_pick  = 8'h00;
               ticks_pick = 16'd1;
            end
            1: begin
               sync_pick  = 8'hFF;
               ticks_pick = 16'hFFFF;
            end
            5: begin
               sync_pick  = rb();
               ticks_pick = 16'($urandom_range(9, 65535));
            end
            default: begin
               sync_pick  = rb();
               ticks_pick = 16'($urandom_range(1, 8));
            end
         endcase
         set_reg(CSR_SYNC_VALUE, {8'h00, sync_pick});
         set_reg(CSR_TIMEOUT_TICKS, ticks_pick);
         no_idle = (p == 2);
         phase_end = items_sent + PHASE_WORDS;
         while (items_sent < phase_end) run_frame();
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      for (int w = 0; w < 5000 && rsp_due.size() != 0; w++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (rsp_due.size() != 0)
         $display("%0t: words outstanding: expected 0 got %0d", $time, rsp_due.size());
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
